@@ src/wsfd_pkg.sv @@
`default_nettype none

package wsfd_pkg;

   localparam logic [31:0] MAX_FRAME_TOTAL_RESET = 32'd1048576;

   localparam logic [3:0] OP_CONTINUATION = 4'h0;
   localparam logic [3:0] OP_BIN_DATA     = 4'h2;

   localparam logic [6:0] LEN_EXT16 = 7'd126;
   localparam logic [6:0] LEN_EXT64 = 7'd127;

   localparam logic [3:0] EXT16_BYTES = 4'd2;
   localparam logic [3:0] EXT64_BYTES = 4'd8;

   localparam logic [3:0] HDR_FIRST_COUNT  = 4'd1;
   localparam logic [3:0] HDR_SECOND_COUNT = 4'd2;

   typedef enum logic [1:0] {
      KIND_HEADER  = 2'd0,
      KIND_PAYLOAD = 2'd1,
      KIND_ERROR   = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ERR_NONE     = 2'd0,
      ERR_FRAGMENT = 2'd1,
      ERR_MASKED   = 2'd2,
      ERR_TOO_LONG = 2'd3
   } err_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] payload_byte;
      logic [3:0] frame_opcode;
      logic       final_flag;
      logic       frame_end;
      err_type    error_code;
   } result_type;

endpackage

`default_nettype wire

@@ src/wsfd_if.sv @@
`default_nettype none

interface wsfd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink (input valid, input data_byte, output ready);
endinterface

interface wsfd_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] payload_byte;
   logic [3:0] frame_opcode;
   logic       final_flag;
   logic       frame_end;
   logic [1:0] error_code;

   modport source (output valid, output kind, output payload_byte, output frame_opcode,
                   output final_flag, output frame_end, output error_code, input ready);
   modport sink (input valid, input kind, input payload_byte, input frame_opcode,
                 input final_flag, input frame_end, input error_code, output ready);
endinterface

interface wsfd_csr_if;
   logic        valid;
   logic        ready;
   logic [31:0] max_frame_total;

   modport source (output valid, output max_frame_total, input ready);
   modport sink (input valid, input max_frame_total, output ready);
endinterface

`default_nettype wire

@@ src/websocket_frame_deframer_core.sv @@
// Channel   Dir  Payload
// req_chan  in   data_byte[7:0]
// rsp_chan  out  kind, payload_byte, frame_opcode, final_flag, frame_end, error_code
// csr_chan  in   max_frame_total[31:0]
//
// One result per input byte, registered for the cycle after the transfer; one byte per cycle
// sustained while rsp_chan is ready, as parser state and result register update together.
// req_chan.ready is high whenever the result register is empty or drains in the same cycle.
// Synchronous reset clears the parser state and loads max_frame_total with 1048576.
// csr_chan is always ready.
`default_nettype none

module websocket_frame_deframer_core (
   input wire logic  clock,
   input wire logic  reset,
   wsfd_req_if.sink  req_chan,
   wsfd_rsp_if.source rsp_chan,
   wsfd_csr_if.sink  csr_chan
);
   import wsfd_pkg::*;

   logic [31:0] max_total_ff;
   logic        rsp_valid_ff;
   result_type  result_ff;
   result_type  result_in;
   logic        take;

   assign csr_chan.ready = 1'b1;
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign take           = req_chan.valid && req_chan.ready;

   wsfd_parse u_parse (
      .clock           (clock),
      .reset           (reset),
      .step            (take),
      .data_byte       (req_chan.data_byte),
      .max_frame_total (max_total_ff),
      .result          (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         max_total_ff <= MAX_FRAME_TOTAL_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_chan.valid) begin
            max_total_ff <= csr_chan.max_frame_total;
         end
         if (take) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         result_ff <= result_in;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.kind         = result_ff.kind;
   assign rsp_chan.payload_byte = result_ff.payload_byte;
   assign rsp_chan.frame_opcode = result_ff.frame_opcode;
   assign rsp_chan.final_flag   = result_ff.final_flag;
   assign rsp_chan.frame_end    = result_ff.frame_end;
   assign rsp_chan.error_code   = result_ff.error_code;

endmodule

`default_nettype wire

@@ src/wsfd_parse.sv @@
`default_nettype none

module wsfd_parse (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                step,
   input  wire logic [7:0]          data_byte,
   input  wire logic [31:0]         max_frame_total,
   output wsfd_pkg::result_type     result
);
   import wsfd_pkg::*;

   typedef enum logic [1:0] {
      PH_FIRST,
      PH_SECOND,
      PH_EXT,
      PH_PAYLOAD
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [3:0]  opcode_ff, opcode_in;
   logic        fin_ff, fin_in;
   logic [3:0]  ext_left_ff, ext_left_in;
   logic [3:0]  hdr_count_ff, hdr_count_in;
   logic [31:0] accum_ff, accum_in;
   logic        big_ff, big_in;
   logic [31:0] payload_left_ff, payload_left_in;
   err_type     err_ff, err_in;

   logic        finish;
   logic        frame_end;
   logic [32:0] total;

   always_comb begin
      phase_in        = phase_ff;
      opcode_in       = opcode_ff;
      fin_in          = fin_ff;
      ext_left_in     = ext_left_ff;
      hdr_count_in    = hdr_count_ff;
      accum_in        = accum_ff;
      big_in          = big_ff;
      payload_left_in = payload_left_ff;
      err_in          = err_ff;
      finish          = 1'b0;
      frame_end       = 1'b0;
      total           = '0;

      if (err_ff == ERR_NONE) begin
         unique case (phase_ff)
            PH_FIRST: begin
               fin_in       = data_byte[7];
               opcode_in    = data_byte[3:0];
               hdr_count_in = HDR_FIRST_COUNT;
               accum_in     = '0;
               big_in       = 1'b0;
               ext_left_in  = '0;
               if (!data_byte[7] && data_byte[3:0] != OP_CONTINUATION
                   && data_byte[3:0] != OP_BIN_DATA) begin
                  err_in = ERR_FRAGMENT;
               end else begin
                  phase_in = PH_SECOND;
               end
            end
            PH_SECOND: begin
               if (data_byte[7]) begin
                  err_in = ERR_MASKED;
               end else begin
                  hdr_count_in = HDR_SECOND_COUNT;
                  if (data_byte[6:0] == LEN_EXT16 || data_byte[6:0] == LEN_EXT64) begin
                     ext_left_in = (data_byte[6:0] == LEN_EXT16) ? EXT16_BYTES : EXT64_BYTES;
                     accum_in    = '0;
                     big_in      = 1'b0;
                     phase_in    = PH_EXT;
                  end else begin
                     accum_in = {25'd0, data_byte[6:0]};
                     big_in   = 1'b0;
                     finish   = 1'b1;
                  end
               end
            end
            PH_EXT: begin
               accum_in     = {accum_ff[23:0], data_byte};
               big_in       = big_ff | (accum_ff[31:24] != 8'd0);
               hdr_count_in = hdr_count_ff + 4'd1;
               ext_left_in  = ext_left_ff - 4'd1;
               finish       = (ext_left_in == 4'd0);
            end
            PH_PAYLOAD: begin
               payload_left_in = payload_left_ff - 32'd1;
               if (payload_left_in == 32'd0) begin
                  frame_end = 1'b1;
                  phase_in  = PH_FIRST;
               end
            end
            default: begin
               phase_in = PH_FIRST;
            end
         endcase

         if (finish) begin
            total = {1'b0, accum_in} + {29'd0, hdr_count_in};
            if (big_in || total > {1'b0, max_frame_total}) begin
               err_in = ERR_TOO_LONG;
            end else begin
               payload_left_in = accum_in;
               if (accum_in == 32'd0) begin
                  frame_end = 1'b1;
                  phase_in  = PH_FIRST;
               end else begin
                  phase_in = PH_PAYLOAD;
               end
            end
         end
      end
   end

   always_comb begin
      result.frame_opcode = opcode_in;
      result.final_flag   = fin_in;
      if (err_in != ERR_NONE) begin
         result.kind         = KIND_ERROR;
         result.payload_byte = '0;
         result.frame_end    = 1'b0;
         result.error_code   = err_in;
      end else begin
         result.kind         = (phase_ff == PH_PAYLOAD) ? KIND_PAYLOAD : KIND_HEADER;
         result.payload_byte = (phase_ff == PH_PAYLOAD) ? data_byte : 8'd0;
         result.frame_end    = frame_end;
         result.error_code   = ERR_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_FIRST;
         opcode_ff       <= '0;
         fin_ff          <= 1'b0;
         ext_left_ff     <= '0;
         hdr_count_ff    <= '0;
         accum_ff        <= '0;
         big_ff          <= 1'b0;
         payload_left_ff <= '0;
         err_ff          <= ERR_NONE;
      end else if (step) begin
         phase_ff        <= phase_in;
         opcode_ff       <= opcode_in;
         fin_ff          <= fin_in;
         ext_left_ff     <= ext_left_in;
         hdr_count_ff    <= hdr_count_in;
         accum_ff        <= accum_in;
         big_ff          <= big_in;
         payload_left_ff <= payload_left_in;
         err_ff          <= err_in;
      end
   end

endmodule

`default_nettype wire

@@ verif/tb_websocket_frame_deframer_core.sv @@
`timescale 1ns / 1ps

module tb_websocket_frame_deframer_core;
   import wsfd_pkg::*;

   localparam int unsigned LIMIT_CYCLES = 1_000_000;
   localparam int unsigned ITEM_TARGET  = 1620;
   localparam int unsigned HOLD_AFTER   = 400;
   localparam int unsigned HOLD_CYCLES  = 300;
   localparam int          DIR_ROWS     = 24;

   localparam logic [3:0] OP_PING      = 4'h9;
   localparam logic [3:0] OP_RSVD_CTRL = 4'hF;

   typedef enum logic [2:0] {
      ST_FIRST,
      ST_LENGTH,
      ST_EXTLEN,
      ST_PAYLOAD
   } parse_state_type;

   typedef struct packed {
      logic [7:0] data;
      logic       lit;
      result_type want;
   } dir_row_type;

   localparam dir_row_type DIR_TABLE [0:DIR_ROWS-1] = '{
      {8'h82, 1'b1, KIND_HEADER,  8'h00, OP_BIN_DATA,  1'b1, 1'b0, ERR_NONE},
      {8'h00, 1'b1, KIND_HEADER,  8'h00, OP_BIN_DATA,  1'b1, 1'b1, ERR_NONE},
      {8'h02, 1'b1, KIND_HEADER,  8'h00, OP_BIN_DATA,  1'b0, 1'b0, ERR_NONE},
      {8'h02, 1'b1, KIND_HEADER,  8'h00, OP_BIN_DATA,  1'b0, 1'b0, ERR_NONE},
      {8'h00, 1'b1, KIND_PAYLOAD, 8'h00, OP_BIN_DATA,  1'b0, 1'b0, ERR_NONE},
      {8'hFF, 1'b1, KIND_PAYLOAD, 8'hFF, OP_BIN_DATA,  1'b0, 1'b1, ERR_NONE},
      {8'h80, 1'b0, 18'h0},
      {8'h7E, 1'b0, 18'h0},
      {8'h00, 1'b0, 18'h0},
      {8'h01, 1'b0, 18'h0},
      {8'hA5, 1'b0, 18'h0},
      {8'hF9, 1'b1, KIND_HEADER,  8'h00, OP_PING,      1'b1, 1'b0, ERR_NONE},
      {8'h7F, 1'b0, 18'h0},
      {8'h00, 1'b0, 18'h0},
      {8'h00, 1'b0, 18'h0},
      {8'h00, 1'b0, 18'h0},
      {8'h00, 1'b0, 18'h0},
      {8'h00, 1'b0, 18'h0},
      {8'h00, 1'b0, 18'h0},
      {8'h00, 1'b0, 18'h0},
      {8'h00, 1'b1, KIND_HEADER,  8'h00, OP_PING,      1'b1, 1'b1, ERR_NONE},
      {8'h8F, 1'b0, 18'h0},
      {8'h01, 1'b0, 18'h0},
      {8'h55, 1'b1, KIND_PAYLOAD, 8'h55, OP_RSVD_CTRL, 1'b1, 1'b1, ERR_NONE}
   };

   logic clock;
   logic reset;

   wsfd_req_if req_bus ();
   wsfd_rsp_if rsp_bus ();
   wsfd_csr_if csr_bus ();

   websocket_frame_deframer_core u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   // parser model state
   parse_state_type st_phase    = ST_FIRST;
   logic [3:0]      st_opcode   = 4'h0;
   logic            st_fin      = 1'b0;
   logic [3:0]      st_ext_left = 4'h0;
   logic [3:0]      st_hdr_cnt  = 4'h0;
   logic [63:0]     st_len      = 64'h0;
   logic [63:0]     st_left     = 64'h0;
   err_type         st_err      = ERR_NONE;
   logic [31:0]     frame_limit = MAX_FRAME_TOTAL_RESET;

   result_type  parsed_q[$];
   int unsigned mismatches = 0;
   int unsigned bytes_sent = 0;
   bit          idle_on    = 1'b1;
   logic        hold_rsp;

   function automatic result_type parse_byte(input logic [7:0] b);
      result_type r;
      kind_type   k;
      logic [7:0] pbyte;
      logic       fend;
      logic       close_hdr;
      logic [64:0] total;
      k         = KIND_HEADER;
      pbyte     = 8'h00;
      fend      = 1'b0;
      close_hdr = 1'b0;
      if (st_err != ERR_NONE) begin
         k = KIND_ERROR;
      end else begin
         case (st_phase)
            ST_FIRST: begin
               st_fin      = b[7];
               st_opcode   = b[3:0];
               st_hdr_cnt  = HDR_FIRST_COUNT;
               st_len      = 64'h0;
               st_ext_left = 4'h0;
               if (!st_fin && st_opcode != OP_CONTINUATION && st_opcode != OP_BIN_DATA) begin
                  st_err = ERR_FRAGMENT;
                  k      = KIND_ERROR;
               end else begin
                  st_phase = ST_LENGTH;
               end
            end
            ST_LENGTH: begin
               if (b[7]) begin
                  st_err = ERR_MASKED;
                  k      = KIND_ERROR;
               end else begin
                  st_hdr_cnt = HDR_SECOND_COUNT;
                  if (b[6:0] == LEN_EXT16 || b[6:0] == LEN_EXT64) begin
                     st_ext_left = (b[6:0] == LEN_EXT16) ? EXT16_BYTES : EXT64_BYTES;
                     st_len      = 64'h0;
                     st_phase    = ST_EXTLEN;
                  end else begin
                     st_len    = {57'h0, b[6:0]};
                     close_hdr = 1'b1;
                  end
               end
            end
            ST_EXTLEN: begin
               st_len     = {st_len[55:0], b};
               st_hdr_cnt = st_hdr_cnt + 4'h1;
               if (st_ext_left != 4'h0) st_ext_left = st_ext_left - 4'h1;
               if (st_ext_left == 4'h0) close_hdr = 1'b1;
            end
            default: begin
               if (st_left != 64'h0) st_left = st_left - 64'h1;
               k     = KIND_PAYLOAD;
               pbyte = b;
               if (st_left == 64'h0) begin
                  st_phase = ST_FIRST;
                  fend     = 1'b1;
               end
            end
         endcase
         if (close_hdr) begin
            total = {1'b0, st_len} + {61'h0, st_hdr_cnt};
            if (total > {33'h0, frame_limit}) begin
               st_err = ERR_TOO_LONG;
               k      = KIND_ERROR;
            end else begin
               st_left = st_len;
               if (st_len == 64'h0) begin
                  st_phase = ST_FIRST;
                  fend     = 1'b1;
               end else begin
                  st_phase = ST_PAYLOAD;
               end
            end
         end
      end
      r.kind         = k;
      r.payload_byte = pbyte;
      r.frame_opcode = st_opcode;
      r.final_flag   = st_fin;
      r.frame_end    = (k == KIND_ERROR) ? 1'b0 : fend;
      r.error_code   = (k == KIND_ERROR) ? st_err : ERR_NONE;
      return r;
   endfunction

   function automatic int unsigned gap_len();
      int unsigned r;
      r = $urandom_range(0, 19);
      if (r < 14) return $urandom_range(1, 3);
      if (r < 19) return $urandom_range(4, 8);
      return $urandom_range(20, 60);
   endfunction

   task automatic push_byte(input logic [7:0] b);
      int unsigned gap;
      gap = (idle_on && $urandom_range(0, 2) == 0) ? gap_len() : 0;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.data_byte <= b;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      parsed_q.push_back(parse_byte(b));
      bytes_sent++;
   endtask

   task automatic drain_results();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (parsed_q.size() != 0) @(posedge clock);
   endtask

   task automatic set_limit(input logic [31:0] v);
      csr_bus.valid           <= 1'b1;
      csr_bus.max_frame_total <= v;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      csr_bus.valid <= 1'b0;
      frame_limit = v;
   endtask

   task automatic send_random_frame();
      logic        fin;
      logic [3:0]  op;
      logic [63:0] len;
      int unsigned enc;
      int unsigned hdr;
      int unsigned cap;
      int unsigned pick;
      fin  = $urandom_range(0, 3) != 0;
      op   = fin ? 4'($urandom_range(0, 15))
                 : ($urandom_range(0, 1) ? OP_BIN_DATA : OP_CONTINUATION);
      pick = $urandom_range(0, 19);
      enc  = (frame_limit < 12) ? 0 : (pick < 12) ? 0 : (pick < 17) ? 1 : 2;
      hdr  = (enc == 0) ? 2 : (enc == 1) ? 4 : 10;
      cap  = (enc == 0) ? 125 : 200;
      if (frame_limit - hdr < cap) cap = frame_limit - hdr;
      pick = $urandom_range(0, 9);
      if (pick < 7) len = 64'($urandom_range(0, 16));
      else if (pick < 9) len = 64'($urandom_range(0, cap));
      else len = 64'(cap);
      if (len > cap) len = 64'(cap);
      push_byte({fin, 3'($urandom_range(0, 7)), op});
      push_byte({1'b0, (enc == 0) ? len[6:0] : (enc == 1) ? LEN_EXT16 : LEN_EXT64});
      for (int i = (enc == 1) ? 1 : (enc == 2) ? 7 : -1; i >= 0; i--)
         push_byte(len[8*i +: 8]);
      repeat (len) push_byte(8'($urandom));
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      int unsigned cycle_count;
      cycle_count = 0;
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // long receiver hold-off to back up the input
   initial begin
      hold_rsp <= 1'b0;
      wait (bytes_sent >= HOLD_AFTER);
      @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   initial begin
      result_type  want;
      int unsigned rsp_pause;
      rsp_pause = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            if (parsed_q.size() == 0) begin
               $error("transfer on rsp_chan with no expected result");
               mismatches++;
            end else begin
               want = parsed_q.pop_front();
               if (rsp_bus.kind !== want.kind) begin
                  $error("kind: expected %0d, actual %0d", want.kind, rsp_bus.kind);
                  mismatches++;
               end
               if (rsp_bus.payload_byte !== want.payload_byte) begin
                  $error("payload_byte: expected %0h, actual %0h",
                         want.payload_byte, rsp_bus.payload_byte);
                  mismatches++;
               end
               if (rsp_bus.frame_opcode !== want.frame_opcode) begin
                  $error("frame_opcode: expected %0h, actual %0h",
                         want.frame_opcode, rsp_bus.frame_opcode);
                  mismatches++;
               end
               if (rsp_bus.final_flag !== want.final_flag) begin
                  $error("final_flag: expected %0d, actual %0d",
                         want.final_flag, rsp_bus.final_flag);
                  mismatches++;
               end
               if (rsp_bus.frame_end !== want.frame_end) begin
                  $error("frame_end: expected %0d, actual %0d",
                         want.frame_end, rsp_bus.frame_end);
                  mismatches++;
               end
               if (rsp_bus.error_code !== want.error_code) begin
                  $error("error_code: expected %0d, actual %0d",
                         want.error_code, rsp_bus.error_code);
                  mismatches++;
               end
            end
         end
         if (hold_rsp) begin
            rsp_bus.ready <= 1'b0;
         end else if (rsp_pause > 0) begin
            rsp_pause--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
            if (idle_on && $urandom_range(0, 4) == 0) rsp_pause = gap_len();
         end
      end
   end

   initial begin
      dir_row_type row;
      logic [31:0] lim;
      logic [15:0] len16;
      logic [3:0]  op;
      int unsigned sel;
      reset                   <= 1'b1;
      req_bus.valid           <= 1'b0;
      req_bus.data_byte       <= 8'h00;
      csr_bus.valid           <= 1'b0;
      csr_bus.max_frame_total <= MAX_FRAME_TOTAL_RESET;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIR_ROWS; i++) begin
         row = DIR_TABLE[i];
         push_byte(row.data);
         if (row.lit) parsed_q[parsed_q.size() - 1] = row.want;
      end

      while (bytes_sent < ITEM_TARGET) begin
         drain_results();
         sel = $urandom_range(0, 9);
         case (sel)
            0:       lim = 32'd2;
            1, 2:    lim = 32'hFFFF_FFFF;
            3, 4:    lim = MAX_FRAME_TOTAL_RESET;
            default: lim = 32'($urandom_range(12, 400));
         endcase
         set_limit(lim);
         idle_on = $urandom_range(0, 3) != 0;
         repeat ($urandom_range(5, 25)) begin
            if (bytes_sent < ITEM_TARGET) send_random_frame();
         end
      end

      // end the stream with one sticky error, then keep feeding bytes
      drain_results();
      idle_on = 1'b1;
      sel = $urandom_range(0, 4);
      case (sel)
         0: begin
            do op = 4'($urandom_range(0, 15));
            while (op == OP_CONTINUATION || op == OP_BIN_DATA);
            push_byte({1'b0, 3'($urandom_range(0, 7)), op});
         end
         1: begin
            push_byte({1'b1, 3'b000, OP_BIN_DATA});
            push_byte({1'b1, 7'($urandom)});
         end
         2: begin
            set_limit(32'($urandom_range(0, 1)));
            push_byte({1'b1, 3'b000, OP_BIN_DATA});
            push_byte({1'b0, 7'($urandom_range(0, 125))});
         end
         3: begin
            push_byte({1'b1, 3'b000, OP_BIN_DATA});
            push_byte({1'b0, LEN_EXT64});
            push_byte({1'b1, 7'($urandom)});
            repeat (7) push_byte(8'($urandom));
         end
         default: begin
            lim = 32'($urandom_range(4, 100));
            set_limit(lim);
            len16 = 16'(lim - 32'd3);
            push_byte({1'b1, 3'b000, OP_BIN_DATA});
            push_byte({1'b0, LEN_EXT16});
            push_byte(len16[15:8]);
            push_byte(len16[7:0]);
         end
      endcase
      repeat ($urandom_range(20, 40)) push_byte(8'($urandom));

      drain_results();
      repeat (5) @(posedge clock);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
